// ----- rtl/fbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbd_pkg: shared types and constants for the fractional baud divisor block
// Fixed-point formats, status codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package fbd_pkg;

  // Operand widths
  localparam int BASE_W    = 32;
  localparam int FRAC_BITS = 7;
  localparam int QUOT_W    = BASE_W + FRAC_BITS;

  // Output word layout
  localparam int FIELD_W   = 12;
  localparam int SCALE_W   = 4;
  localparam int WORD_W    = FIELD_W + SCALE_W;

  // Scaled divisor must reach 2048, i.e. bit 11 of the integer part
  localparam int SCALE_LIMIT_BIT = (FIELD_W - 1) + FRAC_BITS;

  // Default number of scale steps
  localparam int MAX_SCALE_STEPS_DEF = 6;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = BASE_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_CLOCK  = 1'b0,
    CFG_CLOCK_KNOWN = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_SAT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_ROUND
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/fbd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbd_div: bit-serial restoring divider
// Computes floor(base * 2^FRAC_BITS / speed), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [fbd_pkg::BASE_W-1:0]  base,
  input  wire logic [fbd_pkg::BASE_W-1:0]  speed,
  output logic                             done,
  output logic [fbd_pkg::QUOT_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(fbd_pkg::QUOT_W);
  localparam int BW    = fbd_pkg::BASE_W;
  localparam int FB    = fbd_pkg::FRAC_BITS;

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [BW-1:0]    rem;
  logic [BW-1:0]    dvsr;

  logic [BW:0]      shifted;
  logic [BW+1:0]    diff;
  logic             qbit;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quotient[fbd_pkg::QUOT_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvsr};
    qbit    = ~diff[BW+1];
  end

  // Control: load on go, count down one bit per cycle, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(fbd_pkg::QUOT_W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= '0;
      dvsr     <= speed;
      quotient <= {base, FB'(0)};
    end else if (running) begin
      rem      <= qbit ? diff[BW-1:0] : shifted[BW-1:0];
      quotient <= {quotient[fbd_pkg::QUOT_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fractional_baud_divisor_calc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fractional_baud_divisor_calc_core: UART fractional divisor calculator
// Turns a requested baud rate into a 12-bit divisor with a 4-bit scale.
// ----------------------------------------------------------------------------
// Usage:
//   Write base_clock (index 0) and clock_known (index 1) through cfg_we,
//   cfg_index and cfg_data while the block is idle. Pulse start with a
//   baud_rate while busy is low; that beat is taken, and busy rises unless it is answered at once.
//   The result shows on divisor_word and status, marked by done for exactly
//   one cycle; busy is low in that cycle, so a new start may follow.
// Sequence:
//   Unconfigured, zero or too fast requests answer in the cycle after start.
//   Otherwise the bit-serial divider runs, one quotient bit per cycle, then
//   normalization shifts up to MAX_SCALE_STEPS times, rounding follows and
//   then the result beat; busy stays high, so no new start is taken meanwhile.
// Reset:
//   rst clears the configuration to zero and returns the controller to idle.
//   The receiver cannot stall; each result is taken in its done cycle.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_calc_core #(
  parameter int MAX_SCALE_STEPS = fbd_pkg::MAX_SCALE_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [fbd_pkg::BASE_W-1:0]       baud_rate,
  output logic                                  done,
  output logic [fbd_pkg::WORD_W-1:0]            divisor_word,
  output logic [1:0]                            status,
  input  wire logic                             cfg_we,
  input  wire logic [fbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int KW    = $clog2(MAX_SCALE_STEPS + 1);
  localparam int QW    = fbd_pkg::QUOT_W;
  localparam int SUM_W = QW + 1;
  localparam int SW    = fbd_pkg::SCALE_W;

  fbd_pkg::state_t  state, state_next;
  fbd_pkg::status_t status_r;

  logic [fbd_pkg::BASE_W-1:0] base_clock;
  logic                       clock_known;

  logic [fbd_pkg::BASE_W-1:0] speed;
  logic [QW-1:0]              scaled;
  logic [KW-1:0]              k;

  logic          req_none;
  logic          req_range;
  logic          accept;
  logic          div_go;
  logic          div_done;
  logic [QW-1:0] quotient;
  logic          can_shift;
  logic [SUM_W-1:0] rsum;
  logic          rsat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock  <= '0;
      clock_known <= 1'b0;
    end else if (cfg_we) begin
      unique case (fbd_pkg::cfg_index_t'(cfg_index))
        fbd_pkg::CFG_BASE_CLOCK:  base_clock  <= cfg_data;
        fbd_pkg::CFG_CLOCK_KNOWN: clock_known <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the request beat and form the normalization and rounding terms
  always_comb begin
    accept    = start && (state == fbd_pkg::ST_IDLE);
    req_none  = !clock_known || (baud_rate == '0);
    req_range = baud_rate > base_clock;
    can_shift = (k < KW'(MAX_SCALE_STEPS))
             && (scaled[QW-1:fbd_pkg::SCALE_LIMIT_BIT] == '0);
    rsum      = {1'b0, scaled} + SUM_W'(1 << (fbd_pkg::FRAC_BITS - 1));
    rsat      = rsum[SUM_W-1:fbd_pkg::FRAC_BITS+fbd_pkg::FIELD_W] != '0;
  end

  fbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .base     (base_clock),
    .speed    (speed),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbd_pkg::ST_IDLE:  if (accept && !req_none && !req_range) state_next = fbd_pkg::ST_DIV;
      fbd_pkg::ST_DIV:   if (div_done) state_next = fbd_pkg::ST_NORM;
      fbd_pkg::ST_NORM:  if (!can_shift) state_next = fbd_pkg::ST_ROUND;
      fbd_pkg::ST_ROUND: state_next = fbd_pkg::ST_IDLE;
      default:           state_next = fbd_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    busy   = 1'b1;
    div_go = 1'b0;
    unique case (state)
      fbd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept && !req_none && !req_range) div_go = 1'b1;
      end
      fbd_pkg::ST_DIV,
      fbd_pkg::ST_NORM,
      fbd_pkg::ST_ROUND: busy = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fbd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Speed goes straight to the divider; hold nothing but the working value
  assign speed = baud_rate;

  // Normalization: subtract one, then shift left while below the limit and under MAX_SCALE_STEPS shifts
  always_ff @(posedge clk) begin
    if (state == fbd_pkg::ST_DIV && div_done) begin
      scaled <= quotient - QW'(1 << fbd_pkg::FRAC_BITS);
      k      <= '0;
    end else if (state == fbd_pkg::ST_NORM && can_shift) begin
      scaled <= {scaled[QW-2:0], 1'b0};
      k      <= k + 1'b1;
    end
  end

  // Result beat: strobe for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (req_none || req_range)) || (state == fbd_pkg::ST_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_none) begin
      divisor_word <= '0;
      status_r     <= fbd_pkg::STATUS_NONE;
    end else if (accept && req_range) begin
      divisor_word <= '0;
      status_r     <= fbd_pkg::STATUS_RANGE;
    end else if (state == fbd_pkg::ST_ROUND) begin
      divisor_word[fbd_pkg::WORD_W-1:fbd_pkg::FIELD_W] <= SW'(0) - SW'(k);
      divisor_word[fbd_pkg::FIELD_W-1:0] <= rsat ? {fbd_pkg::FIELD_W{1'b1}}
        : rsum[fbd_pkg::FRAC_BITS+fbd_pkg::FIELD_W-1:fbd_pkg::FRAC_BITS];
      status_r <= rsat ? fbd_pkg::STATUS_SAT : fbd_pkg::STATUS_OK;
    end
  end

  assign status = status_r;

  // Checks on the controller
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == fbd_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_k_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == fbd_pkg::ST_NORM || state == fbd_pkg::ST_ROUND)
      |-> k <= KW'(MAX_SCALE_STEPS))
    else $error("scale count beyond its limit");

  a_go_enters_div: assert property (@(posedge clk) disable iff (rst)
    div_go |=> state == fbd_pkg::ST_DIV)
    else $error("divider started without entering the divide state");

  a_round_done: assert property (@(posedge clk) disable iff (rst)
    state == fbd_pkg::ST_ROUND |=> done && !busy)
    else $error("rounding did not deliver a result beat");

endmodule
`default_nettype wire
